[hw/rtl/modexp_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths, modulus constants, controller states and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package modexp_pkg;

    localparam int BASE_W  = 30;
    localparam int EXPN_W  = 32;
    localparam int POWER_W = 30;
    localparam int PROD_W  = 60;
    localparam int QEST_W  = 31;
    localparam int Q2_W    = 62;
    localparam int RED_W   = 32;

    localparam logic [POWER_W-1:0] PRIME_MOD = 30'd998244353;
    localparam logic [RED_W:0]     PRIME_1X  = 33'd998244353;
    localparam logic [RED_W:0]     PRIME_2X  = 33'd1996488706;
    localparam logic [POWER_W-1:0] ONE_VAL   = 30'd1;

    // floor(2^60 / p) for the Barrett quotient estimate
    localparam logic [QEST_W-1:0] BARRETT_M =
        QEST_W'((64'd1 << 60) / 64'd998244353);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_QEST,
        S_QMUL,
        S_FIX,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic qest;
        logic qmul;
        logic fix;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_zero;
    } t_dp_sts;

endpackage

[hw/rtl/modexp_in_if.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation input channel
// Valid/ready channel carrying one base and one exponent per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface modexp_in_if;
    import modexp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base;
    logic [EXPN_W-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

[hw/rtl/modexp_out_if.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation output channel
// Valid/ready channel carrying one power per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface modexp_out_if;
    import modexp_pkg::*;

    logic               valid;
    logic               ready;
    logic [POWER_W-1:0] power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

[hw/rtl/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation
// Computes base^exponent mod 998244353 by right-to-left square and multiply.
//
//   channel   dir   payload                     transfer when
//   i_in      in    base[29:0], exponent[31:0]  valid && ready
//   o_out     out   power[29:0]                 valid && ready
//
// Each item runs the Barrett steps (product, quotient estimate, quotient times
// p, subtract and correct) once for every exponent bit up to the highest set
// one, none for a zero exponent and at most EXP_BITS bits; both multiply lanes
// share this sequence. A new input is accepted only after the result is emitted.
// Reset is synchronous and clears the controller state and the output valid.
// The output register holds a finished result while a new item is accepted;
// a second result waits in the datapath accumulator until that register is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation #(
    parameter int EXP_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    modexp_in_if.sink     i_in,
    modexp_out_if.source  o_out
);
    import modexp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    modexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    modexp_dp #(
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_base     (i_in.base),
        .i_exponent (i_in.exponent),
        .o_sts      (sts),
        .o_power    (o_out.power)
    );
endmodule

[hw/rtl/modexp_mulred.sv]
// ----------------------------------------------------------------------------
// Modular multiply lane
// Multiplies two residues and reduces the product modulo p by Barrett
// reduction over four steps: product, quotient estimate, quotient times p,
// subtract and correct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modexp_mulred (
    input  logic                                i_clk,
    input  modexp_pkg::t_dp_cmd                 i_cmd,
    input  logic [modexp_pkg::POWER_W-1:0]      i_a,
    input  logic [modexp_pkg::POWER_W-1:0]      i_b,
    output logic [modexp_pkg::POWER_W-1:0]      o_res
);
    import modexp_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [Q2_W-1:0]   r_q2;
    logic [Q2_W-1:0]   n_q2;
    logic [RED_W-1:0]  r_qp;
    logic [RED_W-1:0]  n_qp;
    logic [RED_W-1:0]  diff0;
    logic [RED_W:0]    diff1;
    logic [RED_W:0]    diff2;

    assign n_prod = PROD_W'(i_a) * PROD_W'(i_b);
    assign n_q2   = Q2_W'(r_prod[PROD_W-1:PROD_W-QEST_W]) * Q2_W'(BARRETT_M);
    assign n_qp   = RED_W'(r_q2[Q2_W-1:Q2_W-QEST_W]) * RED_W'(PRIME_MOD);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.qest) begin
            r_q2 <= n_q2;
        end
        if (i_cmd.qmul) begin
            r_qp <= n_qp;
        end
    end

    // remainder lies below 3p; drop up to two multiples of p
    assign diff0 = r_prod[RED_W-1:0] - r_qp;
    assign diff1 = {1'b0, diff0} - PRIME_1X;
    assign diff2 = {1'b0, diff0} - PRIME_2X;

    always_comb begin
        if (!diff2[RED_W]) begin
            o_res = diff2[POWER_W-1:0];
        end else if (!diff1[RED_W]) begin
            o_res = diff1[POWER_W-1:0];
        end else begin
            o_res = diff0[POWER_W-1:0];
        end
    end
endmodule

[hw/rtl/modexp_dp.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the running result, the running square and the exponent shift
// register, and drives two multiply lanes: result times square and square
// times square.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modexp_dp #(
    parameter int EXP_BITS = 32
) (
    input  logic                               i_clk,
    input  modexp_pkg::t_dp_cmd                i_cmd,
    input  logic [modexp_pkg::BASE_W-1:0]      i_base,
    input  logic [modexp_pkg::EXPN_W-1:0]      i_exponent,
    output modexp_pkg::t_dp_sts                o_sts,
    output logic [modexp_pkg::POWER_W-1:0]     o_power
);
    import modexp_pkg::*;

    logic [POWER_W-1:0]  r_acc;
    logic [POWER_W-1:0]  r_sq;
    logic [EXP_BITS-1:0] r_exp;
    logic [POWER_W-1:0]  r_power;
    logic [POWER_W-1:0]  n_sq_load;
    logic [POWER_W-1:0]  acc_opnd;
    logic [POWER_W-1:0]  acc_res;
    logic [POWER_W-1:0]  sq_res;

    // base is below 2p, so one subtract reduces it
    assign n_sq_load = (i_base >= PRIME_MOD) ? (i_base - PRIME_MOD) : i_base;

    // multiply by one on a clear bit keeps the result unchanged
    assign acc_opnd = r_exp[0] ? r_sq : ONE_VAL;

    modexp_mulred u_acc_lane (
        .i_clk (i_clk),
        .i_cmd (i_cmd),
        .i_a   (r_acc),
        .i_b   (acc_opnd),
        .o_res (acc_res)
    );

    modexp_mulred u_sq_lane (
        .i_clk (i_clk),
        .i_cmd (i_cmd),
        .i_a   (r_sq),
        .i_b   (r_sq),
        .o_res (sq_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= ONE_VAL;
            r_sq  <= n_sq_load;
            r_exp <= EXP_BITS'(i_exponent);
        end else if (i_cmd.fix) begin
            r_acc <= acc_res;
            r_sq  <= sq_res;
            r_exp <= r_exp >> 1;
        end
        if (i_cmd.emit) begin
            r_power <= r_acc;
        end
    end

    assign o_sts.exp_zero = (r_exp == '0);
    assign o_power        = r_power;
endmodule

[hw/rtl/modexp_ctrl.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences load, the four reduction steps of each exponent bit and the
// write of the output register; owns both channel handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modexp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  modexp_pkg::t_dp_sts  i_sts,
    output modexp_pkg::t_dp_cmd  o_cmd
);
    import modexp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;
    logic    out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = i_sts.exp_zero ? S_EMIT : S_QEST;
            end
            S_QEST: begin
                n_state = S_QMUL;
            end
            S_QMUL: begin
                n_state = S_FIX;
            end
            S_FIX: begin
                n_state = S_MUL;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd        = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                cmd.load   = i_in_valid;
            end
            S_MUL: begin
                cmd.mul = !i_sts.exp_zero;
            end
            S_QEST: begin
                cmd.qest = 1'b1;
            end
            S_QMUL: begin
                cmd.qmul = 1'b1;
            end
            S_FIX: begin
                cmd.fix = 1'b1;
            end
            S_EMIT: begin
                cmd.emit = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign n_out_valid = cmd.emit || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base/exponent pairs through the input channel and checks each power
// against a square-and-multiply predictor modulo 998244353. A short corner
// list covers zero, one and the largest exponents, bases at, below and above
// the prime, and alternating bit patterns. A long random run follows, with
// bursty input, a patterned output stall, two long output holds and pauses
// that let the block drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import modexp_pkg::*;

    class power_scoreboard #(int EXP_BITS = 32);

        logic [POWER_W-1:0] expected_powers[$];
        int unsigned        fail_count;
        int unsigned        noted_count;
        int unsigned        checked_count;

        function new();
            fail_count    = 0;
            noted_count   = 0;
            checked_count = 0;
        endfunction

        function logic [POWER_W-1:0] expected_power(logic [BASE_W-1:0] base,
                                                    logic [EXPN_W-1:0] exponent);
            longint unsigned prime;
            longint unsigned square;
            longint unsigned acc;
            int              k;
            prime  = longint'(PRIME_MOD);
            square = longint'(base) % prime;
            acc    = 1;
            for (k = 0; k < EXP_BITS && k < 64; k++) begin
                if (k < EXPN_W && exponent[k]) begin
                    acc = (acc * square) % prime;
                end
                square = (square * square) % prime;
            end
            return POWER_W'(acc);
        endfunction

        function void note_input(logic [BASE_W-1:0] base, logic [EXPN_W-1:0] exponent);
            expected_powers = {expected_powers, expected_power(base, exponent)};
            noted_count++;
        endfunction

        function void check_power(logic [POWER_W-1:0] actual);
            logic [POWER_W-1:0] expected;
            checked_count++;
            if (expected_powers.size() == 0) begin
                $display("%0t: unexpected power, expected none, actual %0d", $time, actual);
                fail_count++;
            end else begin
                expected = expected_powers.pop_front();
                if (actual !== expected) begin
                    $display("%0t: power mismatch, expected %0d, actual %0d",
                             $time, expected, actual);
                    fail_count++;
                end
            end
        endfunction

        function int outstanding();
            return expected_powers.size();
        endfunction

    endclass

    localparam int EXP_BITS      = 32;
    localparam int RANDOM_ITEMS  = 1580;
    localparam int HOLD_CYCLES   = 600;
    localparam int QUIET_LIMIT   = 4000;
    localparam int N_CORNERS     = 20;
    localparam int BASE_SPAN     = (1 << BASE_W) - 1 - 998244353;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [EXPN_W-1:0] exponent;
    } t_modexp_item;

    logic i_clk;
    logic i_rst_n;
    bit   long_hold_req;
    int   holds_done;
    int   drains_done;
    int   quiet_cycles;

    power_scoreboard #(EXP_BITS) sb;

    modexp_in_if  in_ch ();
    modexp_out_if out_ch ();

    modular_exponentiation #(
        .EXP_BITS (EXP_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_modexp_item corner_items [N_CORNERS] = '{
        '{30'd0,          32'd0},
        '{30'd0,          32'd1},
        '{30'd0,          32'hFFFF_FFFF},
        '{30'd998244353,  32'd0},
        '{30'd998244353,  32'd7},
        '{30'd1,          32'hFFFF_FFFF},
        '{30'h3FFF_FFFF,  32'hFFFF_FFFF},
        '{30'h3FFF_FFFF,  32'd0},
        '{30'h3FFF_FFFF,  32'd1},
        '{30'd998244352,  32'd1},
        '{30'd998244352,  32'd2},
        '{30'd998244352,  32'hFFFF_FFFF},
        '{30'd3,          32'd998244352},
        '{30'd2,          32'h8000_0000},
        '{30'd998244354,  32'd12345},
        '{30'h2AAA_AAAA,  32'h5555_5555},
        '{30'h1555_5555,  32'hAAAA_AAAA},
        '{30'd5,          32'd1},
        '{30'd2,          32'd23},
        '{30'd123456789,  32'd1}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_item(input logic [BASE_W-1:0] base, input logic [EXPN_W-1:0] exponent);
        @(negedge i_clk);
        in_ch.valid    <= 1'b1;
        in_ch.base     <= base;
        in_ch.exponent <= exponent;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        sb.note_input(base, exponent);
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        in_ch.valid    <= 1'b0;
        in_ch.base     <= BASE_W'($urandom);
        in_ch.exponent <= $urandom;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        drains_done++;
    endtask

    // receiver: patterned stall, with an occasional long hold on request
    initial begin
        int unsigned rx_cycle;
        rx_cycle     = 0;
        holds_done   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (long_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                long_hold_req = 1'b0;
                holds_done++;
            end else begin
                case (rx_cycle[9:8])
                    2'd0: out_ch.ready <= 1'b1;
                    2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2'd2: out_ch.ready <= ($urandom_range(0, 9) == 0);
                    default: out_ch.ready <= (rx_cycle[2:0] < 3'd3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_power(out_ch.power);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [BASE_W-1:0] base;
        logic [EXPN_W-1:0] exponent;
        int                burst_left;
        int                gap;
        int                n;
        sb             = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        long_hold_req  = 1'b0;
        drains_done    = 0;
        quiet_cycles   = 0;
        in_ch.valid    = 1'b0;
        in_ch.base     = '0;
        in_ch.exponent = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < N_CORNERS; n++) begin
            send_item(corner_items[n].base, corner_items[n].exponent);
        end
        pause_until_drained();

        burst_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300 || n == 1100) begin
                long_hold_req = 1'b1;
            end
            if (n == 700 || n == 1450) begin
                pause_until_drained();
            end

            case ($urandom_range(0, 9))
                4:       base = BASE_W'($urandom_range(0, 15));
                5, 6:    base = PRIME_MOD + BASE_W'($urandom_range(0, BASE_SPAN));
                7:       base = PRIME_MOD - BASE_W'($urandom_range(0, 15));
                default: base = BASE_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
                5, 6:    exponent = $urandom >> $urandom_range(0, 31);
                7:       exponent = $urandom_range(0, 3);
                8:       exponent = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
                9:       exponent = 32'd998244353 - EXPN_W'($urandom_range(1, 2));
                default: exponent = $urandom;
            endcase
            send_item(base, exponent);

            if (burst_left > 0) begin
                burst_left--;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 6);
                    6, 7, 8:          gap = $urandom_range(7, 140);
                    default:          gap = 0;
                endcase
                if (gap > 0) begin
                    idle_sender(gap);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 8);
            end
        end

        pause_until_drained();
        repeat (4 * EXP_BITS + 8) @(posedge i_clk);

        $display("Sent %0d items (%0d corner cases), checked %0d powers.",
                 sb.noted_count, N_CORNERS, sb.checked_count);
        $display("Long output holds: %0d, drain pauses: %0d.", holds_done, drains_done);
        if (sb.fail_count == 0 && sb.outstanding() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
